### src/smq_pkg.sv
// Package for the sorted minimum priority queue.
// Holds the sizes, item structs, operation and status codes and value conversions.
// No dependencies.
package smq_pkg;

  localparam int DEPTH = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] current_minimum;
    logic [6:0]         entry_total;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic ins;
    logic pop;
    val_t x;
  } cell_ctl_t;

  function automatic val_t to_store(logic signed [31:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic logic signed [31:0] to_out(val_t v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

endpackage

### src/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue: control, count and result.
// Instantiates a row of smq_cell; depends on smq_pkg.
//
// Usage: drive cmd and raise start. The item is accepted at a rising edge with
// start high and busy low. cmd.operation selects insert or pop of the minimum.
// The result appears on result, marked by done, for exactly one cycle; it is
// taken at the edge that ends that cycle, and the receiver cannot stall it.
// done rises at the next edge after the accepting edge; busy is high for the
// single cycle in between, so no new item is taken until busy is low again. In
// that cycle every cell not below the new value takes it or its neighbor's on
// insert, each cell comparing its value with the new one; on pop all shift.
// An insert into a full queue is refused with status full; a pop on an empty
// queue returns zero with status empty. Every result carries the minimum and
// the count after the operation.
// Reset (rst, synchronous) empties the queue and clears busy and done; stored
// cell contents are not cleared and are never read while unoccupied.
module sorted_min_priority_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  smq_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output smq_pkg::result_t result
);

  logic              pending;
  logic              op_q;
  smq_pkg::val_t     x_q;
  smq_pkg::cnt_t     count;
  smq_pkg::cell_ctl_t ctl;
  smq_pkg::val_t     vals [smq_pkg::DEPTH];
  logic [smq_pkg::DEPTH-1:0] lts;
  logic              full;
  logic              empty;

  assign busy  = pending;
  assign full  = (count == smq_pkg::CNT_W'(smq_pkg::DEPTH));
  assign empty = (count == '0);

  assign ctl.ins = pending && (op_q == smq_pkg::OP_INSERT) && !full;
  assign ctl.pop = pending && (op_q == smq_pkg::OP_POP) && !empty;
  assign ctl.x   = x_q;

  for (genvar i = 0; i < smq_pkg::DEPTH; i++) begin : g_cell
    smq_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (count > smq_pkg::CNT_W'(i)),
      .prev_lt    ((i == 0) ? 1'b1 : lts[(i == 0) ? 0 : i - 1]),
      .prev_value (vals[(i == 0) ? 0 : i - 1]),
      .next_value (vals[(i == smq_pkg::DEPTH - 1) ? i : i + 1]),
      .lt         (lts[i]),
      .value      (vals[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= pending;
      if (pending) begin
        pending <= 1'b0;
        if (ctl.ins) begin
          count <= count + 1'b1;
        end else if (ctl.pop) begin
          count <= count - 1'b1;
        end
      end else if (start) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !pending) begin
      op_q <= cmd.operation;
      x_q  <= smq_pkg::to_store(cmd.value);
    end
    if (pending) begin
      if (op_q == smq_pkg::OP_INSERT) begin
        result.popped_value <= '0;
        if (full) begin
          result.current_minimum <= smq_pkg::to_out(vals[0]);
          result.entry_total     <= 7'(count);
          result.status          <= smq_pkg::ST_FULL;
        end else begin
          result.current_minimum <= smq_pkg::to_out(lts[0] ? vals[0] : x_q);
          result.entry_total     <= 7'(count + 1'b1);
          result.status          <= smq_pkg::ST_OK;
        end
      end else begin
        if (empty) begin
          result.popped_value    <= '0;
          result.current_minimum <= '0;
          result.entry_total     <= '0;
          result.status          <= smq_pkg::ST_EMPTY;
        end else begin
          result.popped_value    <= smq_pkg::to_out(vals[0]);
          result.current_minimum <= (count > smq_pkg::CNT_W'(1)) ?
                                    smq_pkg::to_out(vals[1]) : '0;
          result.entry_total     <= 7'(count - 1'b1);
          result.status          <= smq_pkg::ST_OK;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= smq_pkg::CNT_W'(smq_pkg::DEPTH))
    else $error("count exceeds the depth");

  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an accepted item");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.entry_total == 7'(count)))
    else $error("reported total differs from the count");

  a_full_total: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == smq_pkg::ST_FULL)) |->
      (count == smq_pkg::CNT_W'(smq_pkg::DEPTH)))
    else $error("full status with room left");

endmodule

### src/smq_cell.sv
// One cell of the sorted row: holds one stored value.
// Shifts toward its neighbors on insert and pop. Depends on smq_pkg.
module smq_cell (
  input  logic              clk,
  input  smq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  logic              prev_lt,
  input  smq_pkg::val_t     prev_value,
  input  smq_pkg::val_t     next_value,
  output logic              lt,
  output smq_pkg::val_t     value
);

  assign lt = occupied && (value < ctl.x);

  always_ff @(posedge clk) begin
    if (ctl.ins && !lt) begin
      value <= prev_lt ? ctl.x : prev_value;
    end else if (ctl.pop) begin
      value <= next_value;
    end
  end

endmodule
